// File: rtl/core/oar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oar_pkg
// Shared constants and types for the operand address resolver.
// ----------------------------------------------------------------------------
package oar_pkg;

  localparam int OAR_ADDR_BITS = 16;

  localparam logic       REQ_WRITE   = 1'b0;
  localparam logic       REQ_RESOLVE = 1'b1;

  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_ZP   = 4'd1;
  localparam logic [3:0] MODE_ZPX  = 4'd2;
  localparam logic [3:0] MODE_ZPY  = 4'd3;
  localparam logic [3:0] MODE_ABS  = 4'd4;
  localparam logic [3:0] MODE_ABSX = 4'd5;
  localparam logic [3:0] MODE_ABSY = 4'd6;
  localparam logic [3:0] MODE_IND  = 4'd7;
  localparam logic [3:0] MODE_INDX = 4'd8;
  localparam logic [3:0] MODE_INDY = 4'd9;
  localparam logic [3:0] MODE_ACC  = 4'd10;

  localparam logic [1:0] RD_PC1 = 2'd0;
  localparam logic [1:0] RD_PC2 = 2'd1;
  localparam logic [1:0] RD_PLO = 2'd2;
  localparam logic [1:0] RD_PHI = 2'd3;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic [1:0] rd_sel;
    logic       cap_b1;
    logic       cap_b2;
    logic       cap_lo;
    logic       cap_hi;
    logic       emit;
  } oar_cmd_t;

  typedef struct packed {
    logic need_b2;
    logic need_ptr;
  } oar_status_t;

endpackage

// File: rtl/core/operand_address_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// operand_address_resolver
// A write gives no result. A resolve reads the first operand byte, then a
// second operand byte for the absolute modes and indirect, then the pointer
// low and high bytes for indirect, indexed indirect and indirect indexed;
// busy falls in the result cycle, so a new resolve is taken only once the
// last one's result is out, the single memory port serving each operand and
// pointer byte in turn. Synchronous reset clears the sequencer and the result
// strobe; memory is not cleared.
// ----------------------------------------------------------------------------
module operand_address_resolver
  import oar_pkg::*;
#(
  parameter int ADDR_BITS = OAR_ADDR_BITS
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_opcode_addr,
  input  logic [7:0]  in_index_x,
  input  logic [7:0]  in_index_y,
  input  logic [15:0] in_write_addr,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  output logic [15:0] out_eff_addr,
  output logic        out_is_accum,
  output logic        out_has_addr,
  output logic [15:0] out_next_pc
);

  oar_cmd_t    cmd;
  oar_status_t status;

  oar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  oar_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_mode        (in_mode),
    .in_opcode_addr (in_opcode_addr),
    .in_index_x     (in_index_x),
    .in_index_y     (in_index_y),
    .in_write_addr  (in_write_addr),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_eff_addr   (out_eff_addr),
    .out_is_accum   (out_is_accum),
    .out_has_addr   (out_has_addr),
    .out_next_pc    (out_next_pc)
  );

endmodule

// File: rtl/core/oar_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oar_ctrl
// Sequencer that steps the datapath through operand and pointer reads.
// ----------------------------------------------------------------------------
module oar_ctrl
  import oar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        req_type,
  input  oar_status_t status,
  output logic        busy,
  output oar_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_B1   = 3'd2;
  localparam logic [2:0] S_B2   = 3'd3;
  localparam logic [2:0] S_PLO  = 3'd4;
  localparam logic [2:0] S_PHI  = 3'd5;
  localparam logic [2:0] S_PEND = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_PC1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_RD1;
          end
        end
      end
      S_RD1: begin
        cmd.rd_sel = RD_PC1;
        state_nxt  = S_B1;
      end
      S_B1: begin
        cmd.cap_b1 = 1'b1;
        cmd.rd_sel = RD_PC2;
        if (status.need_b2) begin
          state_nxt = S_B2;
        end else if (status.need_ptr) begin
          state_nxt = S_PLO;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_B2: begin
        cmd.cap_b2 = 1'b1;
        state_nxt  = status.need_ptr ? S_PLO : S_DONE;
      end
      S_PLO: begin
        cmd.rd_sel = RD_PLO;
        state_nxt  = S_PHI;
      end
      S_PHI: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_sel = RD_PHI;
        state_nxt  = S_PEND;
      end
      S_PEND: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/oar_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oar_dp
// Byte memory, operand and pointer registers and effective address logic.
// ----------------------------------------------------------------------------
module oar_dp
  import oar_pkg::*;
#(
  parameter int ADDR_BITS = OAR_ADDR_BITS
)(
  input  logic        clk,
  input  logic        rst_n,
  input  oar_cmd_t    cmd,
  output oar_status_t status,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_opcode_addr,
  input  logic [7:0]  in_index_x,
  input  logic [7:0]  in_index_y,
  input  logic [15:0] in_write_addr,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  output logic [15:0] out_eff_addr,
  output logic        out_is_accum,
  output logic        out_has_addr,
  output logic [15:0] out_next_pc
);

  localparam int          MEM_DEPTH = 1 << ADDR_BITS;
  localparam logic [15:0] AMASK     = 16'((32'd1 << ADDR_BITS) - 32'd1);

  logic [7:0] mem [MEM_DEPTH];

  logic [3:0]  mode_r;
  logic [15:0] pc_r;
  logic [7:0]  x_r;
  logic [7:0]  y_r;
  logic [7:0]  b1_r;
  logic [7:0]  b2_r;
  logic [7:0]  lo_r;
  logic [7:0]  hi_r;
  logic [7:0]  rdata_r;
  logic        out_valid_r;
  logic [15:0] eff_r;
  logic        accum_r;
  logic        has_r;
  logic [15:0] npc_r;

  logic [15:0] ptr_base;
  logic [15:0] ptr_next;
  logic [15:0] rd_addr;
  logic [15:0] port_addr;
  logic [15:0] word;
  logic [15:0] ptr_word;
  logic [15:0] eff_nxt;
  logic        accum_nxt;
  logic        has_nxt;
  logic [1:0]  used;
  logic [15:0] npc_nxt;

  always_comb begin
    status.need_b2  = (mode_r inside {MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND});
    status.need_ptr = (mode_r inside {MODE_IND, MODE_INDX, MODE_INDY});
  end

  always_comb begin
    case (mode_r)
      MODE_IND:  ptr_base = {b2_r, b1_r};
      MODE_INDX: ptr_base = {8'h00, 8'(b1_r + x_r)};
      default:   ptr_base = {8'h00, b1_r};
    endcase
    if (mode_r == MODE_IND) begin
      ptr_next = ptr_base + 16'd1;
    end else begin
      ptr_next = {8'h00, 8'(ptr_base[7:0] + 8'd1)};
    end
    case (cmd.rd_sel)
      RD_PC1:  rd_addr = pc_r + 16'd1;
      RD_PC2:  rd_addr = pc_r + 16'd2;
      RD_PLO:  rd_addr = ptr_base;
      RD_PHI:  rd_addr = ptr_next;
      default: rd_addr = pc_r;
    endcase
    port_addr = cmd.wr ? in_write_addr : rd_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[port_addr[ADDR_BITS-1:0]] <= in_write_data;
    end
    rdata_r <= mem[port_addr[ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      pc_r   <= in_opcode_addr & AMASK;
      x_r    <= in_index_x;
      y_r    <= in_index_y;
    end
    if (cmd.cap_b1) begin
      b1_r <= rdata_r;
    end
    if (cmd.cap_b2) begin
      b2_r <= rdata_r;
    end
    if (cmd.cap_lo) begin
      lo_r <= rdata_r;
    end
    if (cmd.cap_hi) begin
      hi_r <= rdata_r;
    end
  end

  always_comb begin
    word      = {b2_r, b1_r};
    ptr_word  = {hi_r, lo_r};
    eff_nxt   = 16'd0;
    accum_nxt = 1'b0;
    has_nxt   = 1'b1;
    used      = 2'd0;
    case (mode_r)
      MODE_IMM: begin
        eff_nxt = pc_r + 16'd1;
        used    = 2'd1;
      end
      MODE_ZP: begin
        eff_nxt = {8'h00, b1_r};
        used    = 2'd1;
      end
      MODE_ZPX: begin
        eff_nxt = {8'h00, 8'(b1_r + x_r)};
        used    = 2'd1;
      end
      MODE_ZPY: begin
        eff_nxt = {8'h00, 8'(b1_r + y_r)};
        used    = 2'd1;
      end
      MODE_ABS: begin
        eff_nxt = word;
        used    = 2'd2;
      end
      MODE_ABSX: begin
        eff_nxt = word + {8'h00, x_r};
        used    = 2'd2;
      end
      MODE_ABSY: begin
        eff_nxt = word + {8'h00, y_r};
        used    = 2'd2;
      end
      MODE_IND: begin
        eff_nxt = ptr_word;
        used    = 2'd2;
      end
      MODE_INDX: begin
        eff_nxt = ptr_word;
        used    = 2'd1;
      end
      MODE_INDY: begin
        eff_nxt = ptr_word + {8'h00, y_r};
        used    = 2'd1;
      end
      MODE_ACC: begin
        accum_nxt = 1'b1;
        has_nxt   = 1'b0;
      end
      default: begin
        has_nxt = 1'b0;
      end
    endcase
    eff_nxt = eff_nxt & AMASK;
    npc_nxt = (pc_r + {14'd0, used}) & AMASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      eff_r   <= eff_nxt;
      accum_r <= accum_nxt;
      has_r   <= has_nxt;
      npc_r   <= npc_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_eff_addr = eff_r;
  assign out_is_accum = accum_r;
  assign out_has_addr = has_r;
  assign out_next_pc  = npc_r;

endmodule
